/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the checker file txrb_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked every edge outside reset
`define ASSERT_CLKD(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// checked every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

/* sv/txrb_pkg.sv */
// ----------------------------------------------------------------------------
// txrb_pkg
// types and constants of the transmit ring buffer with dma chunking
// ----------------------------------------------------------------------------
package txrb_pkg;

  localparam int BUFFER_DEPTH_DEF = 1024;
  localparam int DATA_W           = 8;
  localparam int ADDR_W           = 10;
  localparam int LENGTH_W         = 11;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_DONE   = 2'd1,
    OP_REFUSE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DROP  = 2'd1,
    ST_RETRY = 2'd2
  } status_t;

  // classified input beat as held in the queue
  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] data;
    logic              eob;
    logic              irq;
    logic [ADDR_W-1:0] addr;
    logic              addr_ok;
  } cmd_t;

endpackage

/* sv/txrb_ifs.sv */
// ----------------------------------------------------------------------------
// txrb_ifs
// valid/ready channels for input beats and result beats
// ----------------------------------------------------------------------------
interface txrb_in_if;
  import txrb_pkg::*;
  logic              valid;
  logic              ready;
  op_t               opcode;
  logic [DATA_W-1:0] data_byte;
  logic              end_of_block;
  logic              from_interrupt;
  logic [ADDR_W-1:0] read_address;

  modport source (output valid, opcode, data_byte, end_of_block, from_interrupt,
                  read_address, input ready);
  modport sink (input valid, opcode, data_byte, end_of_block, from_interrupt,
                read_address, output ready);
endinterface

interface txrb_out_if;
  import txrb_pkg::*;
  logic                valid;
  logic                ready;
  status_t             status;
  logic                dma_request;
  logic [ADDR_W-1:0]   dma_start;
  logic [LENGTH_W-1:0] dma_length;
  logic [DATA_W-1:0]   read_data;

  modport source (output valid, status, dma_request, dma_start, dma_length, read_data,
                  input ready);
  modport sink (input valid, status, dma_request, dma_start, dma_length, read_data,
                output ready);
endinterface

/* sv/txrb_front.sv */
// ----------------------------------------------------------------------------
// txrb_front
// accepts input beats, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module txrb_front #(
  parameter int BUFFER_DEPTH = txrb_pkg::BUFFER_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  txrb_in_if.sink       req,
  output logic          cmd_valid,
  output txrb_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import txrb_pkg::*;

  cmd_t        ent [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;
  logic        push;
  cmd_t        cmd_in;
  logic [31:0] addr_ext;

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = ent[rptr];

  always_comb begin
    addr_ext       = 32'(req.read_address);
    cmd_in.op      = req.opcode;
    cmd_in.data    = req.data_byte;
    cmd_in.eob     = req.end_of_block;
    cmd_in.irq     = req.from_interrupt;
    cmd_in.addr    = req.read_address;
    cmd_in.addr_ok = (addr_ext < 32'(BUFFER_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (cmd_pop) begin
        rptr <= ~rptr;
      end
      case ({push, cmd_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/txrb_back.sv */
// ----------------------------------------------------------------------------
// txrb_back
// ring positions, byte store, chunk start and the registered result beat
// ----------------------------------------------------------------------------
module txrb_back #(
  parameter int BUFFER_DEPTH = txrb_pkg::BUFFER_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  txrb_pkg::cmd_t cmd,
  output logic           cmd_pop,
  txrb_out_if.source     res
);
  import txrb_pkg::*;

  localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int LEN_W = $clog2(BUFFER_DEPTH + 1);
  localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(BUFFER_DEPTH);

  logic [DATA_W-1:0] mem [BUFFER_DEPTH];

  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  rp;
  logic              wrapped;
  logic [LEN_W-1:0]  fl;
  logic [PTR_W-1:0]  wp_next;
  logic [PTR_W-1:0]  rp_next;
  logic              wrapped_next;
  logic [LEN_W-1:0]  fl_next;

  logic              out_valid;
  status_t           status;
  logic              dma_request;
  logic [ADDR_W-1:0] dma_start;
  logic [LENGTH_W-1:0] dma_length;
  logic              rd_sel;
  logic [DATA_W-1:0] rd_q;

  logic              empty;
  logic              try_start;
  logic              do_write;
  logic [LEN_W-1:0]  wp_inc;
  logic [LEN_W-1:0]  rp_sum;
  logic [LEN_W-1:0]  chunk_len;
  status_t           status_next;
  logic [31:0]       start_ext;
  logic [31:0]       len_ext;
  logic [31:0]       raddr_ext;
  logic [PTR_W-1:0]  ridx;
  logic [PTR_W-1:0]  widx;

  assign cmd_pop = cmd_valid && (!out_valid || res.ready);

  assign res.valid       = out_valid;
  assign res.status      = status;
  assign res.dma_request = dma_request;
  assign res.dma_start   = dma_start;
  assign res.dma_length  = dma_length;
  assign res.read_data   = rd_sel ? rd_q : '0;

  always_comb begin
    empty        = !wrapped && (rp == wp);
    wp_next      = wp;
    rp_next      = rp;
    wrapped_next = wrapped;
    fl_next      = fl;
    status_next  = ST_OK;
    try_start    = 1'b0;
    do_write     = 1'b0;
    wp_inc       = '0;
    rp_sum       = '0;
    chunk_len    = '0;
    case (cmd.op)
      OP_PUSH: begin
        if (empty) begin
          wp_next      = '0;
          rp_next      = '0;
          wrapped_next = 1'b0;
          fl_next      = '0;
        end
        if (wrapped_next && (rp_next == wp_next)) begin
          status_next = cmd.irq ? ST_DROP : ST_RETRY;
          try_start   = 1'b1;
        end else begin
          do_write = 1'b1;
          wp_inc   = LEN_W'(wp_next) + LEN_W'(1);
          if (wp_inc >= DEPTH_L) begin
            wp_next      = '0;
            wrapped_next = 1'b1;
          end else begin
            wp_next = wp_inc[PTR_W-1:0];
          end
          try_start = cmd.eob;
        end
      end
      OP_DONE: begin
        rp_sum  = LEN_W'(rp) + fl;
        fl_next = '0;
        if (rp_sum >= DEPTH_L) begin
          rp_next      = '0;
          wrapped_next = 1'b0;
        end else begin
          rp_next = rp_sum[PTR_W-1:0];
        end
        try_start = 1'b1;
      end
      OP_REFUSE: begin
        fl_next = '0;
      end
      default: ;
    endcase
    if (try_start && (fl_next == '0)) begin
      if (wrapped_next || (rp_next > wp_next)) begin
        chunk_len = DEPTH_L - LEN_W'(rp_next);
      end else begin
        chunk_len = LEN_W'(wp_next) - LEN_W'(rp_next);
      end
      fl_next = chunk_len;
    end
    start_ext = 32'(rp_next);
    len_ext   = 32'(chunk_len);
    raddr_ext = 32'(cmd.addr);
    ridx      = raddr_ext[PTR_W-1:0];
    widx      = empty ? '0 : wp;
  end

  // byte store, at most one write or one read per popped beat
  always_ff @(posedge clk) begin
    if (cmd_pop && do_write) begin
      mem[widx] <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && (cmd.op == OP_READ) && cmd.addr_ok) begin
      rd_q <= mem[ridx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      rp        <= '0;
      wrapped   <= 1'b0;
      fl        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd_pop) begin
        wp        <= wp_next;
        rp        <= rp_next;
        wrapped   <= wrapped_next;
        fl        <= fl_next;
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      status      <= status_next;
      dma_request <= (chunk_len != '0);
      dma_start   <= (chunk_len != '0) ? start_ext[ADDR_W-1:0] : '0;
      dma_length  <= len_ext[LENGTH_W-1:0];
      rd_sel      <= (cmd.op == OP_READ) && cmd.addr_ok;
    end
  end

endmodule

/* sv/tx_ring_buffer_dma_chunker.sv */
// an accepted input beat is held in the front queue, then its result beat is registered by the back end
// throughput: one beat per cycle while the result output is not stalled, set by the single
//   position update and the at most one store access (write or read) the back end makes per beat
// a two-entry queue sits between the front and back ends
// reset: rst clears positions, wrap flag, in-flight length, queue and output valid
// the byte store is not cleared and holds undefined data until written
// ----------------------------------------------------------------------------
// tx_ring_buffer_dma_chunker
// transmit ring buffer that hands contiguous chunks to a dma engine
// ----------------------------------------------------------------------------
module tx_ring_buffer_dma_chunker #(
  parameter int BUFFER_DEPTH = txrb_pkg::BUFFER_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  txrb_in_if.sink    req,
  txrb_out_if.source res
);
  import txrb_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  txrb_front #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  txrb_back #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res       (res)
  );

endmodule

/* sv/txrb_checker.sv */
// ----------------------------------------------------------------------------
// txrb_checker
// port-level checks on the result channel of the ring buffer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module txrb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          dma_request,
  input logic [txrb_pkg::ADDR_W-1:0]   dma_start,
  input logic [txrb_pkg::LENGTH_W-1:0] dma_length
);
  import txrb_pkg::*;

  // a stalled result beat stays valid and keeps its dma_length
  `ASSERT_CLKD(a_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(dma_length))

  // a started chunk is never empty
  `ASSERT_CLKD(a_req_len, clk, rst, out_valid && dma_request |-> dma_length != '0)

  // no chunk means zero start and length
  `ASSERT_CLKD(a_idle_zero, clk, rst,
    out_valid && !dma_request |-> dma_start == '0 && dma_length == '0)

  // no result beat right after reset
  `ASSERT_ALWAYS(a_rst_quiet, clk, rst |=> !out_valid)

endmodule

bind tx_ring_buffer_dma_chunker txrb_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (res.valid),
  .out_ready   (res.ready),
  .dma_request (res.dma_request),
  .dma_start   (res.dma_start),
  .dma_length  (res.dma_length)
);
